// ===== hdl/lj_trial_move_energy_assert.svh =====
// Assertion macros shared by the trial move energy block.
`ifndef LJ_TRIAL_MOVE_ENERGY_ASSERT_SVH
`define LJ_TRIAL_MOVE_ENERGY_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LJTME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lj_trial_move_energy: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define LJTME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lj_trial_move_energy: next-cycle check failed");

`endif

// ===== hdl/ljtme_pkg.sv =====
// Package: constants, types and arithmetic helpers of the trial move energy block.
`timescale 1ns / 1ps
package ljtme_pkg;

	localparam int FRAC_BITS = 16;
	localparam int POS_W = 22;
	localparam int E_W = 48;
	localparam int BOX_W = 23;
	localparam int SHIFT_W = 18;
	localparam int CNT_W = 8;
	localparam int IDX_W = 7;
	localparam int REQ_W = 2;
	localparam int R2F_W = 22;
	localparam int INV_W = 2 * FRAC_BITS + 1;
	localparam int IN_TDATA_W = 56;
	localparam int OUT_TDATA_W = 144;
	localparam int DEF_MAX_PARTICLES = 128;

	// request codes
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TRIAL = 2'd1;
	localparam logic [REQ_W-1:0] REQ_COMMIT = 2'd2;

	// register indexes
	localparam logic [1:0] CFG_PARTICLE_COUNT = 2'd0;
	localparam logic [1:0] CFG_BOX_LENGTH = 2'd1;
	localparam logic [1:0] CFG_CUTOFF_SQ = 2'd2;
	localparam logic [1:0] CFG_ENERGY_SHIFT = 2'd3;

	// register reset values
	localparam logic [CNT_W-1:0] RST_COUNT = 8'd100;
	localparam logic [BOX_W-1:0] RST_BOX = 23'd2621440;
	localparam logic [BOX_W-1:0] RST_CUTOFF = 23'd409600;
	localparam logic signed [SHIFT_W-1:0] RST_SHIFT = -18'sd1069;

	// multiplier operand selects
	localparam logic [1:0] MUL_SEL_INV2SQ = 2'd0;
	localparam logic [1:0] MUL_SEL_CUBE = 2'd1;
	localparam logic [1:0] MUL_SEL_SIXSQ = 2'd2;

	localparam logic [63:0] CAP = 64'h4000_0000_0000_0000;
	localparam logic signed [63:0] DIFF_LIM = 64'sh0004_0000_0000_0000;
	localparam logic signed [63:0] E_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] E_MIN64 = 64'shFFFF_8000_0000_0000;
	localparam logic [E_W-1:0] E_MAX = {1'b0, {(E_W-1){1'b1}}};
	localparam logic [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};
	localparam int POS_MAX_I = 2 ** (POS_W - 1) - 1;
	localparam int POS_MIN_I = -(2 ** (POS_W - 1));

	typedef struct packed {
		logic capture;
		logic mem_write_req;
		logic commit;
		logic rd_self;
		logic wrap;
		logic j_clr;
		logic rd_j;
		logic j_inc;
		logic pass_set;
		logic pass_clr;
		logic diff;
		logic img;
		logic sq;
		logic r2;
		logic div_start;
		logic mul_start;
		logic [1:0] mul_sel;
		logic inv2_ld;
		logic inv6_ld;
		logic term_zero;
		logic term_calc;
		logic acc;
		logic out_load;
	} ljtme_cmd_t;

	typedef struct packed {
		logic kind_write;
		logic kind_trial;
		logic kind_commit;
		logic self_ok;
		logic j_end;
		logic j_skip;
		logic pass;
		logic counted;
		logic r2_zero;
		logic div_done;
		logic mul_done;
		logic out_free;
	} ljtme_status_t;

	// old + displacement, wrapped once into the box, then saturated
	function automatic logic signed [POS_W-1:0] wrap_pos(
		input logic signed [POS_W-1:0] o,
		input logic signed [POS_W-1:0] c,
		input logic [BOX_W-1:0] len
	);
		logic signed [POS_W+3:0] p;
		logic signed [POS_W+3:0] p2;
		logic signed [POS_W+3:0] lz;
		logic signed [POS_W+3:0] r;
		p = (POS_W+4)'(o) + (POS_W+4)'(c);
		p2 = p <<< 1;
		lz = $signed({3'b000, len});
		r = p;
		if (p2 >= lz)
			r = p - lz;
		else if (p2 < -lz)
			r = p + lz;
		if (r > (POS_W+4)'(POS_MAX_I))
			r = (POS_W+4)'(POS_MAX_I);
		else if (r < (POS_W+4)'(POS_MIN_I))
			r = (POS_W+4)'(POS_MIN_I);
		return POS_W'(r);
	endfunction

	// minimum image of one coordinate difference
	function automatic logic signed [POS_W+2:0] min_img(
		input logic signed [POS_W:0] d,
		input logic [BOX_W-1:0] len
	);
		logic signed [POS_W+2:0] de;
		logic signed [POS_W+2:0] lz;
		logic [POS_W+1:0] mag;
		de = (POS_W+3)'(d);
		lz = $signed({2'b00, len});
		mag = (de < 0) ? (POS_W+2)'(-de) : (POS_W+2)'(de);
		if ({mag, 1'b0} > {2'b00, len})
			de = (de > 0) ? de - lz : de + lz;
		return de;
	endfunction

	// pair term from inv12 and inv6; top bit is the clip flag
	function automatic logic [E_W:0] pair_term(
		input logic [63:0] inv12,
		input logic [63:0] inv6,
		input logic signed [SHIFT_W-1:0] sh
	);
		logic signed [63:0] d;
		logic signed [63:0] v;
		logic [E_W:0] r;
		d = $signed(inv12) - $signed(inv6);
		v = (d <<< 2) - 64'(sh);
		if (inv12 >= CAP)
			r = {1'b1, E_MAX};
		else if (d > DIFF_LIM)
			r = {1'b1, E_MAX};
		else if (d < -DIFF_LIM)
			r = {1'b1, E_MIN};
		else if (v > E_MAX64)
			r = {1'b1, E_MAX};
		else if (v < E_MIN64)
			r = {1'b1, E_MIN};
		else
			r = {1'b0, v[E_W-1:0]};
		return r;
	endfunction

endpackage

// ===== hdl/ljtme_div.sv =====
// Radix-2 restoring divider computing 2^(2F) / divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module ljtme_div
	import ljtme_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [R2F_W-1:0]   divisor,
	output logic               done,
	output logic [INV_W-1:0]   quot
);

	logic                busy_q;
	logic                done_q;
	logic [5:0]          cnt_q;
	logic [R2F_W-1:0]    rem_q;
	logic [R2F_W-1:0]    dvs_q;
	logic [INV_W-1:0]    quot_q;
	logic                bit_in;
	logic [R2F_W:0]      trial;
	logic                ge;

	// dividend is a single one at the top bit position
	assign bit_in = (cnt_q == 6'(INV_W - 1));
	assign trial = {rem_q, bit_in};
	assign ge = (trial >= {1'b0, dvs_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(INV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quot_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? R2F_W'(trial - {1'b0, dvs_q}) : R2F_W'(trial);
			quot_q <= {quot_q[INV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== hdl/ljtme_mul.sv =====
// 64x64 fixed-point multiplier from four registered 32x32 partial products, capped result.
`timescale 1ns / 1ps
module ljtme_mul
	import ljtme_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] res
);

	logic         busy_q;
	logic         done_q;
	logic [2:0]   cnt_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [63:0]  pp_q;
	logic [1:0]   sh_q;
	logic [127:0] acc_q;
	logic [31:0]  xa;
	logic [31:0]  xb;
	logic [127:0] pp_shifted;

	// partial product k: a half by cnt[1], b half by cnt[0]
	assign xa = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign xb = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (sh_q)
			2'd0: pp_shifted = {64'd0, pp_q};
			2'd1: pp_shifted = {32'd0, pp_q, 32'd0};
			2'd2: pp_shifted = {pp_q, 64'd0};
			default: pp_shifted = '0;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	// product register, then accumulate in the next cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_q <= xa * xb;
				sh_q <= 2'({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]});
			end
			if (cnt_q != 3'd0)
				acc_q <= acc_q + pp_shifted;
		end
	end

	// drop fraction bits; anything past 64 bits caps
	assign res = (|acc_q[127:64]) ? CAP : 64'(acc_q[63:FRAC_BITS]);
	assign done = done_q;

endmodule

// ===== hdl/ljtme_ctrl.sv =====
// Controller state machine sequencing requests, the partner sweep and the pair unit.
`timescale 1ns / 1ps
module ljtme_ctrl
	import ljtme_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  ljtme_status_t status,
	output ljtme_cmd_t    cmd
);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_DECODE = 5'd1;
	localparam logic [4:0] ST_WRAP   = 5'd2;
	localparam logic [4:0] ST_J_CHK  = 5'd3;
	localparam logic [4:0] ST_DIFF   = 5'd4;
	localparam logic [4:0] ST_IMG    = 5'd5;
	localparam logic [4:0] ST_SQ     = 5'd6;
	localparam logic [4:0] ST_R2     = 5'd7;
	localparam logic [4:0] ST_EVAL   = 5'd8;
	localparam logic [4:0] ST_DIV    = 5'd9;
	localparam logic [4:0] ST_MUL1   = 5'd10;
	localparam logic [4:0] ST_MUL2   = 5'd11;
	localparam logic [4:0] ST_MUL3   = 5'd12;
	localparam logic [4:0] ST_ACC    = 5'd13;
	localparam logic [4:0] ST_NEXT   = 5'd14;
	localparam logic [4:0] ST_DONE   = 5'd15;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign s_tready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.kind_write) begin
					cmd.mem_write_req = 1'b1;
					state_d = ST_DONE;
				end else if (status.kind_commit) begin
					cmd.commit = 1'b1;
					state_d = ST_DONE;
				end else if (status.kind_trial) begin
					cmd.rd_self = 1'b1;
					state_d = ST_WRAP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_WRAP: begin
				cmd.wrap = 1'b1;
				cmd.j_clr = 1'b1;
				state_d = status.self_ok ? ST_J_CHK : ST_DONE;
			end
			ST_J_CHK: begin
				if (status.j_end) begin
					state_d = ST_DONE;
				end else if (status.j_skip) begin
					cmd.j_inc = 1'b1;
				end else begin
					cmd.rd_j = 1'b1;
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_IMG;
			end
			ST_IMG: begin
				cmd.img = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq = 1'b1;
				state_d = ST_R2;
			end
			ST_R2: begin
				cmd.r2 = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (!status.counted) begin
					state_d = ST_NEXT;
				end else if (status.r2_zero) begin
					cmd.term_zero = 1'b1;
					state_d = ST_ACC;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					cmd.inv2_ld = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MUL_SEL_INV2SQ;
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				if (status.mul_done) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MUL_SEL_CUBE;
					state_d = ST_MUL2;
				end
			end
			ST_MUL2: begin
				if (status.mul_done) begin
					cmd.inv6_ld = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MUL_SEL_SIXSQ;
					state_d = ST_MUL3;
				end
			end
			ST_MUL3: begin
				if (status.mul_done) begin
					cmd.term_calc = 1'b1;
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				// old position first, then trial position, same partner
				if (!status.pass) begin
					cmd.pass_set = 1'b1;
					state_d = ST_DIFF;
				end else begin
					cmd.pass_clr = 1'b1;
					cmd.j_inc = 1'b1;
					state_d = ST_J_CHK;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/ljtme_dp.sv =====
// Datapath: registers, position memory, partner sweep, pair arithmetic and result register.
`timescale 1ns / 1ps
module ljtme_dp
	import ljtme_pkg::*;
#(
	parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_addr,
	input  logic [BOX_W-1:0]       cfg_wdata,
	input  logic [IN_TDATA_W-1:0]  in_data,
	input  ljtme_cmd_t             cmd,
	output ljtme_status_t          status,
	input  logic                   m_tready,
	output logic                   m_tvalid,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int IW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES + 1);

	// configuration
	logic [CNT_W-1:0]          count_q;
	logic [BOX_W-1:0]          box_q;
	logic [BOX_W-1:0]          cut_q;
	logic signed [SHIFT_W-1:0] eshift_q;

	// captured request
	logic [REQ_W-1:0]          req_q;
	logic [IDX_W-1:0]          idx_q;
	logic signed [POS_W-1:0]   cx_q;
	logic signed [POS_W-1:0]   cy_q;
	logic                      present_q;

	// stores
	logic [2*POS_W-1:0]        pos_mem [MAX_PARTICLES];
	logic [2*POS_W-1:0]        rd_q;
	logic [MAX_PARTICLES-1:0]  active_q;
	logic                      pend_v_q;
	logic [IW-1:0]             pend_slot_q;
	logic signed [POS_W-1:0]   pend_x_q;
	logic signed [POS_W-1:0]   pend_y_q;

	// sweep and positions
	logic signed [POS_W-1:0]   ox_q;
	logic signed [POS_W-1:0]   oy_q;
	logic signed [POS_W-1:0]   tx_q;
	logic signed [POS_W-1:0]   ty_q;
	logic [CW-1:0]             j_q;
	logic                      pass_q;

	// pair pipeline
	logic signed [POS_W:0]     ddx_s1;
	logic signed [POS_W:0]     ddy_s1;
	logic signed [POS_W+2:0]   mix_s2;
	logic signed [POS_W+2:0]   miy_s2;
	logic [45:0]               sqx_s3;
	logic [45:0]               sqy_s3;
	logic                      counted_s4;
	logic                      r2z_s4;
	logic [R2F_W-1:0]          r2f_s4;

	logic [63:0]               inv2_q;
	logic [63:0]               inv6_q;
	logic [E_W-1:0]            term_q;
	logic                      tflag_q;
	logic [E_W-1:0]            acc_old_q;
	logic [E_W-1:0]            acc_new_q;
	logic                      flag_q;

	logic                      out_v_q;
	logic [OUT_TDATA_W-1:0]    out_q;

	logic                      idx_ok;
	logic [IW-1:0]             slot;
	logic [IW-1:0]             jslot;
	logic [CW-1:0]             n_w;
	logic                      mem_we;
	logic [IW-1:0]             mem_wa;
	logic [2*POS_W-1:0]        mem_wd;
	logic                      mem_re;
	logic [IW-1:0]             mem_ra;
	logic signed [POS_W-1:0]   ox_w;
	logic signed [POS_W-1:0]   oy_w;
	logic signed [POS_W-1:0]   tx_w;
	logic signed [POS_W-1:0]   ty_w;
	logic signed [POS_W-1:0]   px_w;
	logic signed [POS_W-1:0]   py_w;
	logic signed [POS_W-1:0]   cenx;
	logic signed [POS_W-1:0]   ceny;
	logic signed [2*POS_W+5:0] sqx_full;
	logic signed [2*POS_W+5:0] sqy_full;
	logic [46:0]               r2_w;
	logic [46:0]               lim_w;
	logic                      div_done;
	logic [INV_W-1:0]          quot;
	logic                      mul_done;
	logic [63:0]               mul_res;
	logic [63:0]               mul_a;
	logic [63:0]               mul_b;
	logic [E_W:0]              term_w;
	logic [E_W-1:0]            acc_cur;
	logic signed [E_W:0]       acc_sum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RST_COUNT;
			box_q <= RST_BOX;
			cut_q <= RST_CUTOFF;
			eshift_q <= RST_SHIFT;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_PARTICLE_COUNT: count_q <= cfg_wdata[CNT_W-1:0];
				CFG_BOX_LENGTH:     box_q <= cfg_wdata;
				CFG_CUTOFF_SQ:      cut_q <= cfg_wdata;
				CFG_ENERGY_SHIFT:   eshift_q <= $signed(cfg_wdata[SHIFT_W-1:0]);
				default: ;
			endcase
		end
	end

	// request capture; result fields start at zero
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data[1:0];
			idx_q <= in_data[8:2];
			cx_q <= $signed(in_data[30:9]);
			cy_q <= $signed(in_data[52:31]);
			present_q <= in_data[53];
		end
	end

	assign idx_ok = ({25'd0, idx_q} < 32'(MAX_PARTICLES));
	assign slot = IW'(idx_q);
	assign jslot = j_q[IW-1:0];
	assign n_w = ({24'd0, count_q} > 32'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES) : CW'(count_q);

	// position memory: one write port, one registered read port
	assign mem_we = cmd.mem_write_req || cmd.commit;
	assign mem_wa = cmd.commit ? pend_slot_q : slot;
	assign mem_wd = cmd.commit ? {pend_y_q, pend_x_q} : {cy_q, cx_q};
	assign mem_re = cmd.rd_self || cmd.rd_j;
	assign mem_ra = cmd.rd_j ? jslot : slot;

	always_ff @(posedge clk) begin
		if (mem_we)
			pos_mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= pos_mem[mem_ra];
	end

	// trial position from the stored one
	assign ox_w = $signed(rd_q[POS_W-1:0]);
	assign oy_w = $signed(rd_q[2*POS_W-1:POS_W]);
	assign tx_w = wrap_pos(ox_w, cx_q, box_q);
	assign ty_w = wrap_pos(oy_w, cy_q, box_q);

	// active flags and pending trial
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			pend_v_q <= 1'b0;
			pend_slot_q <= '0;
			pend_x_q <= '0;
			pend_y_q <= '0;
		end else begin
			if (cmd.mem_write_req) begin
				active_q[slot] <= present_q;
				pend_v_q <= 1'b0;
			end
			if (cmd.commit)
				pend_v_q <= 1'b0;
			if (cmd.wrap) begin
				pend_v_q <= 1'b1;
				pend_slot_q <= slot;
				pend_x_q <= tx_w;
				pend_y_q <= ty_w;
			end
		end
	end

	assign px_w = pend_x_q;
	assign py_w = pend_y_q;

	// positions, result position and sweep counters
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tx_q <= '0;
			ty_q <= '0;
		end else if (cmd.wrap) begin
			ox_q <= ox_w;
			oy_q <= oy_w;
			tx_q <= tx_w;
			ty_q <= ty_w;
		end else if (cmd.commit) begin
			tx_q <= px_w;
			ty_q <= py_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			pass_q <= 1'b0;
		end else begin
			if (cmd.j_clr)
				j_q <= '0;
			else if (cmd.j_inc)
				j_q <= j_q + CW'(1);
			if (cmd.j_clr || cmd.pass_clr)
				pass_q <= 1'b0;
			else if (cmd.pass_set)
				pass_q <= 1'b1;
		end
	end

	// pair pipeline: difference, minimum image, squares, distance
	assign cenx = pass_q ? tx_q : ox_q;
	assign ceny = pass_q ? ty_q : oy_q;
	assign sqx_full = mix_s2 * mix_s2;
	assign sqy_full = miy_s2 * miy_s2;
	assign r2_w = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign lim_w = {8'd0, cut_q, 16'd0};

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			ddx_s1 <= (POS_W+1)'(ox_w) - (POS_W+1)'(cenx);
			ddy_s1 <= (POS_W+1)'(oy_w) - (POS_W+1)'(ceny);
		end
		if (cmd.img) begin
			mix_s2 <= min_img(ddx_s1, box_q);
			miy_s2 <= min_img(ddy_s1, box_q);
		end
		if (cmd.sq) begin
			sqx_s3 <= sqx_full[45:0];
			sqy_s3 <= sqy_full[45:0];
		end
		if (cmd.r2) begin
			counted_s4 <= (r2_w < lim_w);
			r2z_s4 <= (r2_w[46:FRAC_BITS] == '0);
			r2f_s4 <= r2_w[FRAC_BITS+R2F_W-1:FRAC_BITS];
		end
	end

	// inverse square and the power chain
	ljtme_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.divisor (r2f_s4),
		.done    (div_done),
		.quot    (quot)
	);

	always_comb begin
		case (cmd.mul_sel)
			MUL_SEL_INV2SQ: begin
				mul_a = 64'(quot);
				mul_b = 64'(quot);
			end
			MUL_SEL_CUBE: begin
				mul_a = mul_res;
				mul_b = inv2_q;
			end
			MUL_SEL_SIXSQ: begin
				mul_a = mul_res;
				mul_b = mul_res;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ljtme_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	// pair term and saturating sums
	assign term_w = pair_term(mul_res, inv6_q, eshift_q);
	assign acc_cur = pass_q ? acc_new_q : acc_old_q;
	assign acc_sum = $signed({acc_cur[E_W-1], acc_cur}) + $signed({term_q[E_W-1], term_q});

	always_ff @(posedge clk) begin
		if (cmd.inv2_ld)
			inv2_q <= 64'(quot);
		if (cmd.inv6_ld)
			inv6_q <= mul_res;
		if (cmd.term_zero) begin
			term_q <= E_MAX;
			tflag_q <= 1'b1;
		end else if (cmd.term_calc) begin
			term_q <= term_w[E_W-1:0];
			tflag_q <= term_w[E_W];
		end
		if (cmd.capture) begin
			acc_old_q <= '0;
			acc_new_q <= '0;
			flag_q <= 1'b0;
		end else if (cmd.acc) begin
			if (acc_sum[E_W] != acc_sum[E_W-1]) begin
				if (pass_q)
					acc_new_q <= acc_sum[E_W] ? E_MIN : E_MAX;
				else
					acc_old_q <= acc_sum[E_W] ? E_MIN : E_MAX;
				flag_q <= 1'b1;
			end else begin
				if (pass_q)
					acc_new_q <= acc_sum[E_W-1:0];
				else
					acc_old_q <= acc_sum[E_W-1:0];
				flag_q <= flag_q | tflag_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (cmd.out_load)
			out_v_q <= 1'b1;
		else if (m_tready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_q <= {3'b000, flag_q, ty_q, tx_q, acc_new_q, acc_old_q};
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	// status back to the controller
	assign status.kind_write = (req_q == REQ_WRITE) && idx_ok;
	assign status.kind_trial = (req_q == REQ_TRIAL) && idx_ok;
	assign status.kind_commit = (req_q == REQ_COMMIT) && pend_v_q;
	assign status.self_ok = active_q[slot] && ({1'b0, idx_q} < count_q);
	assign status.j_end = (j_q == n_w);
	assign status.j_skip = (jslot == slot) || !active_q[jslot];
	assign status.pass = pass_q;
	assign status.counted = counted_s4;
	assign status.r2_zero = r2z_s4;
	assign status.div_done = div_done;
	assign status.mul_done = mul_done;
	assign status.out_free = !out_v_q || m_tready;

endmodule

// ===== hdl/lj_trial_move_energy.sv =====
// Lennard-Jones trial move energy unit: top level joining controller and datapath.
// Usage:
//   Requests enter on the s_ group, one item per request; each request gives
//   exactly one result item on the m_ group. Write loads a particle slot,
//   trial displaces a stored particle and returns its energy at the stored
//   and at the wrapped trial position, commit stores the last trial position.
//   Configuration goes through cfg_we/cfg_addr/cfg_wdata while the block idles.
// Sequencing:
//   Write, commit and ignored requests go from decode to the result register.
//   A trial sweeps the n slots in use; for each active partner it forms the
//   distance at the stored and at the trial position, and for each of the two
//   inside the cutoff at nonzero distance runs the divider and three multiplies
//   of the shared pair unit. One request at a time.
// Reset:
//   Registers take their default values, all slots become inactive and no
//   trial is pending. Positions hold no value until written.
// Stalls:
//   The result waits in an output register; the next request is accepted
//   meanwhile, and its result is held back until the waiting one is taken.
`timescale 1ns / 1ps
`include "lj_trial_move_energy_assert.svh"
module lj_trial_move_energy
	import ljtme_pkg::*;
#(
	parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// req_type[1:0], particle_index[8:2], coord_x[30:9], coord_y[52:31], present[53]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// energy_old[47:0], energy_new[95:48], trial_x[117:96], trial_y[139:118],
	// saturated[140]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_addr,
	input  logic [BOX_W-1:0]       cfg_wdata
);

	ljtme_cmd_t    cmd;
	ljtme_status_t status;

	ljtme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ljtme_dp #(
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

	// checks
	`LJTME_ASSERT_NOW(a_load_into_free, clk, arst_n, cmd.out_load, status.out_free)
	`LJTME_ASSERT_NEXT(a_load_shows_valid, clk, arst_n, cmd.out_load, m_tvalid)
	`LJTME_ASSERT_NOW(a_accept_captures, clk, arst_n, s_tvalid && s_tready, cmd.capture)

endmodule

// ===== sim/lj_trial_move_energy_test.sv =====
// Testbench for the Lennard-Jones trial move energy unit: stimulus, prediction and checking.
`timescale 1ns / 1ps
module lj_trial_move_energy_test;
	import ljtme_pkg::*;

	localparam int SLOTS = 128;
	localparam longint E_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint E_LO = 64'shFFFF_8000_0000_0000;
	localparam longint unsigned MUL_CAP = 64'h4000_0000_0000_0000;
	localparam longint DIFF_CAP = 64'sh0004_0000_0000_0000;
	localparam longint P_HI = 2097151;
	localparam longint P_LO = -2097152;
	localparam logic [1:0] REQ_NONE = 2'd3;

	typedef struct {
		logic [47:0] e_old;
		logic [47:0] e_new;
		logic [21:0] tx;
		logic [21:0] ty;
		logic sat;
	} energy_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [1:0] cfg_addr;
	logic [BOX_W-1:0] cfg_wdata;

	// mirror of the block state
	int unsigned count_r;
	longint box_r;
	longint unsigned cut_r;
	longint shift_r;
	longint pos_x [SLOTS];
	longint pos_y [SLOTS];
	bit active_r [SLOTS];
	bit written_r [SLOTS];
	longint pend_x;
	longint pend_y;
	int unsigned pend_slot;
	bit sat_seen;

	energy_result_t energy_q[$];
	int errors;
	int n_trials;
	int n_sat;
	int n_commits;
	bit src_idle;
	bit sink_idle;

	lj_trial_move_energy dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------- predictor ----------------
	function automatic longint clamp48(longint v);
		if (v > E_HI) begin
			sat_seen = 1'b1;
			return E_HI;
		end
		if (v < E_LO) begin
			sat_seen = 1'b1;
			return E_LO;
		end
		return v;
	endfunction

	function automatic longint unsigned mul_frac(longint unsigned a, longint unsigned b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		if (p[127:64] != 64'd0)
			return MUL_CAP;
		p = p >> FRAC_BITS;
		if (p > {64'd0, MUL_CAP})
			return MUL_CAP;
		return p[63:0];
	endfunction

	function automatic longint nearest_image(longint d);
		longint a;
		a = (d < 0) ? -d : d;
		if (2 * a > box_r)
			d = (d > 0) ? d - box_r : d + box_r;
		return d;
	endfunction

	function automatic longint wrap_coord(longint p);
		if (2 * p >= box_r)
			p = p - box_r;
		else if (2 * p < -box_r)
			p = p + box_r;
		if (p > P_HI)
			p = P_HI;
		if (p < P_LO)
			p = P_LO;
		return p;
	endfunction

	function automatic longint lj_pair(longint unsigned r2);
		longint unsigned r2f;
		longint unsigned inv2;
		longint unsigned inv6;
		longint unsigned inv12;
		longint d;
		r2f = r2 >> FRAC_BITS;
		if (r2f == 0) begin
			sat_seen = 1'b1;
			return E_HI;
		end
		inv2 = (64'd1 << (2 * FRAC_BITS)) / r2f;
		inv6 = mul_frac(mul_frac(inv2, inv2), inv2);
		inv12 = mul_frac(inv6, inv6);
		if (inv12 >= MUL_CAP) begin
			sat_seen = 1'b1;
			return E_HI;
		end
		d = longint'(inv12) - longint'(inv6);
		if (d > DIFF_CAP) begin
			sat_seen = 1'b1;
			return E_HI;
		end
		if (d < -DIFF_CAP) begin
			sat_seen = 1'b1;
			return E_LO;
		end
		return clamp48(4 * d - shift_r);
	endfunction

	function automatic longint particle_energy(longint x, longint y, int self, int n);
		longint acc;
		longint dx;
		longint dy;
		longint unsigned r2;
		acc = 0;
		for (int j = 0; j < n; j++) begin
			if (j == self || !active_r[j])
				continue;
			dx = nearest_image(pos_x[j] - x);
			dy = nearest_image(pos_y[j] - y);
			r2 = longint'(dx * dx) + longint'(dy * dy);
			if (r2 < (cut_r << FRAC_BITS))
				acc = clamp48(acc + lj_pair(r2));
		end
		return acc;
	endfunction

	// update the mirror for one accepted request and queue its result
	task automatic predict_request(logic [1:0] req, int idx, longint cx, longint cy, bit pres);
		energy_result_t r;
		longint eo;
		longint en;
		longint tx;
		longint ty;
		int n;
		eo = 0;
		en = 0;
		tx = 0;
		ty = 0;
		sat_seen = 1'b0;
		n = (count_r > SLOTS) ? SLOTS : count_r;
		if (req == REQ_WRITE) begin
			pos_x[idx] = cx;
			pos_y[idx] = cy;
			active_r[idx] = pres;
			written_r[idx] = 1'b1;
			pend_slot = SLOTS;
		end else if (req == REQ_TRIAL) begin
			tx = wrap_coord(pos_x[idx] + cx);
			ty = wrap_coord(pos_y[idx] + cy);
			if (active_r[idx] && idx < n) begin
				eo = particle_energy(pos_x[idx], pos_y[idx], idx, n);
				en = particle_energy(tx, ty, idx, n);
			end
			pend_x = tx;
			pend_y = ty;
			pend_slot = idx;
			n_trials++;
		end else if (req == REQ_COMMIT && pend_slot < SLOTS) begin
			pos_x[pend_slot] = pend_x;
			pos_y[pend_slot] = pend_y;
			tx = pend_x;
			ty = pend_y;
			pend_slot = SLOTS;
			n_commits++;
		end
		if (sat_seen)
			n_sat++;
		r.e_old = eo[47:0];
		r.e_new = en[47:0];
		r.tx = tx[21:0];
		r.ty = ty[21:0];
		r.sat = sat_seen;
		energy_q.push_back(r);
	endtask

	// ---------------- driving ----------------
	task automatic send_request(logic [1:0] req, int idx, longint cx, longint cy, bit pres);
		logic [21:0] bx;
		logic [21:0] by;
		bx = cx[21:0];
		by = cy[21:0];
		if (src_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tdata <= {2'b00, pres, by, bx, idx[6:0], req};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		predict_request(req, idx, $signed(bx), $signed(by), pres);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (energy_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// one write cycle, then write enable dropped and the mirror updated
	task automatic write_reg(logic [1:0] addr, longint value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value[BOX_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (addr)
			CFG_PARTICLE_COUNT: count_r = value[7:0];
			CFG_BOX_LENGTH: box_r = value[22:0];
			CFG_CUTOFF_SQ: cut_r = value[22:0];
			default: shift_r = $signed(value[17:0]);
		endcase
	endtask

	task automatic set_regs(int cnt, longint box, longint cut, longint sh);
		wait_drained();
		write_reg(CFG_PARTICLE_COUNT, cnt);
		write_reg(CFG_BOX_LENGTH, box);
		write_reg(CFG_CUTOFF_SQ, cut);
		write_reg(CFG_ENERGY_SHIFT, sh);
	endtask

	function automatic longint any22();
		return $signed(22'($urandom));
	endfunction

	function automatic longint in_box();
		return longint'($urandom_range(0, box_r - 1)) - box_r / 2;
	endfunction

	function automatic longint small_step();
		longint s;
		s = box_r / 8 + 1;
		return longint'($urandom_range(0, 2 * s)) - s;
	endfunction

	// ---------------- checking ----------------
	task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
		$display("ERROR %0t: %s got %h want %h", $realtime, field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		energy_result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (energy_q.size() == 0) begin
				report_mismatch("unexpected item", m_tdata[47:0], 48'd0);
			end else begin
				w = energy_q.pop_front();
				if (m_tdata[47:0] !== w.e_old)
					report_mismatch("energy_old", m_tdata[47:0], w.e_old);
				if (m_tdata[95:48] !== w.e_new)
					report_mismatch("energy_new", m_tdata[95:48], w.e_new);
				if (m_tdata[117:96] !== w.tx)
					report_mismatch("trial_x", m_tdata[117:96], w.tx);
				if (m_tdata[139:118] !== w.ty)
					report_mismatch("trial_y", m_tdata[139:118], w.ty);
				if (m_tdata[140] !== w.sat)
					report_mismatch("saturated", m_tdata[140], w.sat);
			end
		end
	end

	// result side backpressure in bursts while sink_idle is set
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(negedge clk);
			if (sink_idle) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16) - 1) @(negedge clk);
			end
		end
	end

	// ---------------- tests ----------------
	// hand-picked geometry: zero distance, hard core, image across the edge
	task automatic test_directed();
		set_regs(8, 2621440, 409600, -1069);
		send_request(REQ_WRITE, 0, 0, 0, 1);
		send_request(REQ_WRITE, 1, 0, 0, 1);
		send_request(REQ_WRITE, 2, 72090, 0, 1);
		send_request(REQ_WRITE, 3, 0, 6554, 1);
		send_request(REQ_WRITE, 4, 1304166, 0, 1);
		send_request(REQ_WRITE, 5, 131072, 131072, 0);
		send_request(REQ_WRITE, 6, -1304166, 0, 1);
		send_request(REQ_WRITE, 7, 98304, 98304, 1);
		send_request(REQ_WRITE, 10, 196608, 196608, 1);
		send_request(REQ_TRIAL, 0, 0, 0, 0);
		send_request(REQ_TRIAL, 2, 6554, 0, 0);
		send_request(REQ_TRIAL, 4, 13107, 0, 0);
		send_request(REQ_COMMIT, 0, 0, 0, 0);
		send_request(REQ_TRIAL, 6, P_HI, P_LO, 0);
		send_request(REQ_TRIAL, 6, P_LO, P_HI, 0);
		send_request(REQ_COMMIT, 127, P_HI, P_HI, 1);
		send_request(REQ_COMMIT, 0, 0, 0, 0);
		send_request(REQ_TRIAL, 7, -3277, 3277, 1);
		send_request(REQ_WRITE, 7, 98304, 98304, 1);
		send_request(REQ_COMMIT, 0, 0, 0, 0);
		send_request(REQ_TRIAL, 5, 65536, 0, 0);
		send_request(REQ_TRIAL, 10, 0, 65536, 0);
		send_request(REQ_NONE, 127, P_LO, P_LO, 1);
		send_request(REQ_TRIAL, 3, 0, 0, 0);
	endtask

	// one phase: fill the slots in use, then mostly trial/commit traffic
	task automatic run_phase(int cnt, longint box, longint cut, longint sh, int items);
		int n;
		int idx;
		int pick;
		set_regs(cnt, box, cut, sh);
		n = (cnt > SLOTS) ? SLOTS : cnt;
		for (int i = 0; i < n; i++)
			send_request(REQ_WRITE, i, in_box(), in_box(), $urandom_range(0, 9) != 0);
		for (int k = 0; k < items; k++) begin
			pick = $urandom_range(0, 99);
			idx = $urandom_range(0, SLOTS - 1);
			if (!written_r[idx])
				idx = $urandom_range(0, n - 1);
			if (pick < 45) begin
				send_request(REQ_TRIAL, $urandom_range(0, n - 1), small_step(), small_step(),
					$urandom_range(0, 1));
				if ($urandom_range(0, 1))
					send_request(REQ_COMMIT, $urandom_range(0, 127), any22(), any22(), 0);
			end else if (pick < 70) begin
				send_request(REQ_WRITE, $urandom_range(0, n - 1), in_box(), in_box(),
					$urandom_range(0, 6) != 0);
			end else if (pick < 80) begin
				send_request(REQ_COMMIT, $urandom_range(0, 127), any22(), any22(),
					$urandom_range(0, 1));
			end else if (pick < 88) begin
				send_request(REQ_WRITE, $urandom_range(0, 127), any22(), any22(),
					$urandom_range(0, 1));
			end else if (pick < 94) begin
				send_request(REQ_NONE, $urandom_range(0, 127), any22(), any22(),
					$urandom_range(0, 1));
			end else begin
				send_request(REQ_TRIAL, idx, any22(), any22(), $urandom_range(0, 1));
			end
		end
	endtask

	task automatic test_register_extremes();
		run_phase(1, 65536, 1, -65536, 12);
		run_phase(2, 65536, 4194304, 65536, 12);
		run_phase(128, 4194304, 4194304, 65536, 8);
		run_phase(255, 4194304, 409600, 0, 6);
		run_phase(24, 4194304, 1, -65536, 20);
	endtask

	task automatic test_random_moves();
		for (int p = 0; p < 6; p++)
			run_phase($urandom_range(2, 24), $urandom_range(65536, 4194304),
				$urandom_range(1, 4194304), longint'($urandom_range(0, 131072)) - 65536, 150);
	endtask

	task automatic test_full_rate();
		src_idle = 1'b0;
		sink_idle = 1'b0;
		run_phase(16, 2621440, 409600, -1069, 150);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_addr <= CFG_PARTICLE_COUNT;
		cfg_wdata <= '0;
		count_r = RST_COUNT;
		box_r = RST_BOX;
		cut_r = RST_CUTOFF;
		shift_r = RST_SHIFT;
		for (int i = 0; i < SLOTS; i++) begin
			pos_x[i] = 0;
			pos_y[i] = 0;
			active_r[i] = 1'b0;
			written_r[i] = 1'b0;
		end
		pend_x = 0;
		pend_y = 0;
		pend_slot = SLOTS;
		errors = 0;
		n_trials = 0;
		n_sat = 0;
		n_commits = 0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_register_extremes();
		test_random_moves();
		test_full_rate();
		wait_drained();
		repeat (40) @(negedge clk);
		$display("covered %0d trial moves, %0d commits, %0d clipped results",
			n_trials, n_commits, n_sat);
		$display("register extremes, random geometries and a full-rate phase checked");
		if (errors == 0)
			$display("lj_trial_move_energy: match");
		else
			$display("lj_trial_move_energy: mismatch");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("timeout with %0d items outstanding", energy_q.size());
		$display("lj_trial_move_energy: mismatch");
		$finish;
	end

endmodule
